// File: sv/olist_pkg.sv
// shared types and constants for the ordered list engine
`default_nettype none

package olist_pkg;

   localparam int DEFAULT_CAPACITY = 16;
   localparam int CMD_W            = 3;
   localparam int POS_W            = 5;
   localparam int DATA_W           = 32;
   localparam int COUNT_OUT_W      = 5;

   typedef enum logic [CMD_W-1:0] {
      CMD_INSERT    = 3'd0,
      CMD_DEL_KEY   = 3'd1,
      CMD_DEL_AT    = 3'd2,
      CMD_READ_AT   = 3'd3,
      CMD_SEARCH    = 3'd4,
      CMD_CLEAR     = 3'd5
   } cmd_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;    // capture the request word
      logic find;    // match and range check
      logic apply;   // shift, write back and load the response word
   } ctl_type;

endpackage

`default_nettype wire

// File: sv/ordered_list_engine.sv
// ordered list engine: top level joining controller and datapath
//
// a bounded ordered list of signed 32-bit values addressed by 1-based position
// request word (req_cmd, req_position, req_value) enters on req_valid/req_ready;
// one response word per request leaves on rsp_valid/rsp_ready
// commands: insert, delete key, delete at position, read, search, clear
// every response carries the count and empty flag after the command
// a taken request word passes the find and apply states; the response word is
// registered in apply; each request takes a match step over the cell row
// followed by a shift and write-back step
// the next request is taken in the write-back cycle while the response
// register is free or being drained
// a stalled response holds its word; write-back waits until the response
// register frees, and no new request is taken meanwhile
// reset empties the list (count to zero); cell contents are not cleared
`default_nettype none

module ordered_list_engine
   import olist_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [CMD_W-1:0]         req_cmd,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic                          rsp_ok,
   output logic signed [DATA_W-1:0]      rsp_item_value,
   output logic [POS_W-1:0]              rsp_found_position,
   output logic signed [DATA_W-1:0]      rsp_prev_value,
   output logic signed [DATA_W-1:0]      rsp_next_value,
   output logic                          rsp_match_is_last,
   output logic [COUNT_OUT_W-1:0]        rsp_list_count,
   output logic                          rsp_list_empty
);

   ctl_type ctl;

   olist_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl)
   );

   olist_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .ctl                (ctl),
      .req_cmd            (req_cmd),
      .req_position       (req_position),
      .req_value          (req_value),
      .rsp_ok             (rsp_ok),
      .rsp_item_value     (rsp_item_value),
      .rsp_found_position (rsp_found_position),
      .rsp_prev_value     (rsp_prev_value),
      .rsp_next_value     (rsp_next_value),
      .rsp_match_is_last  (rsp_match_is_last),
      .rsp_list_count     (rsp_list_count),
      .rsp_list_empty     (rsp_list_empty)
   );

endmodule

`default_nettype wire

// File: sv/olist_ctrl.sv
// controller for the ordered list engine: request sequencing and response valid
`default_nettype none

module olist_ctrl
   import olist_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output ctl_type      ctl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FIND,
      ST_APPLY
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;
   logic      apply_go;
   logic      accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign apply_go  = (state_ff == ST_APPLY) && out_free;
   assign req_ready = (state_ff == ST_IDLE) || apply_go;
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   assign ctl.load  = accept;
   assign ctl.find  = (state_ff == ST_FIND);
   assign ctl.apply = apply_go;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_FIND;
         end
         ST_FIND: begin
            state_in = ST_APPLY;
         end
         ST_APPLY: begin
            if (apply_go) state_in = accept ? ST_FIND : ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (apply_go) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTH
   a_find_then_apply: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIND |=> state_ff == ST_APPLY)
      else $error("find not followed by apply");

   a_accept_to_find: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == ST_FIND)
      else $error("accepted word did not start a find");

   a_rsp_from_apply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_APPLY))
      else $error("response raised outside apply");
`endif

endmodule

`default_nettype wire

// File: sv/olist_dp.sv
// datapath for the ordered list engine: cell row, match, shift and response word
`default_nettype none

module olist_dp
   import olist_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire ctl_type                  ctl,
   input  wire logic [CMD_W-1:0]         req_cmd,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [DATA_W-1:0] req_value,
   output logic                          rsp_ok,
   output logic signed [DATA_W-1:0]      rsp_item_value,
   output logic [POS_W-1:0]              rsp_found_position,
   output logic signed [DATA_W-1:0]      rsp_prev_value,
   output logic signed [DATA_W-1:0]      rsp_next_value,
   output logic                          rsp_match_is_last,
   output logic [COUNT_OUT_W-1:0]        rsp_list_count,
   output logic                          rsp_list_empty
);

   localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int KW = ((CW > POS_W) ? CW : POS_W) + 1;

   logic [DATA_W-1:0] cells_ff [CAPACITY];
   logic [DATA_W-1:0] cells_in [CAPACITY];
   logic [CW-1:0]     cnt_ff;
   logic [CW-1:0]     cnt_in;

   cmd_type           cmd_ff;
   logic [POS_W-1:0]  pos_ff;
   logic [DATA_W-1:0] val_ff;
   logic [IW-1:0]     tgt_ff;
   logic              hit_ff;

   logic              found;
   logic [IW-1:0]     midx;
   logic [POS_W-1:0]  pos_m1;
   logic [KW-1:0]     pos_k;
   logic [KW-1:0]     cnt_k;
   logic [IW-1:0]     tgt_in;
   logic              hit_in;

   logic [DATA_W-1:0] rd_item;
   logic [DATA_W-1:0] rd_prev;
   logic [DATA_W-1:0] rd_next;
   logic              nxt_ok;
   logic [IW-1:0]     tgt_p1;
   logic [IW-1:0]     tgt_m1;

   logic              ok_ff;
   logic [DATA_W-1:0] item_ff;
   logic [POS_W-1:0]  fpos_ff;
   logic [DATA_W-1:0] prev_ff;
   logic [DATA_W-1:0] next_ff;
   logic              last_ff;
   logic [CW-1:0]     cnt_rsp_ff;

   // first match among the live cells
   always_comb begin
      found = 1'b0;
      midx  = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if ((i < int'(cnt_ff)) && (cells_ff[i] == val_ff)) begin
            found = 1'b1;
            midx  = IW'(i);
         end
      end
   end

   assign pos_m1 = pos_ff - POS_W'(1);
   assign pos_k  = KW'(pos_ff);
   assign cnt_k  = KW'(cnt_ff);

   always_comb begin
      tgt_in = IW'(pos_m1);
      hit_in = 1'b0;
      unique case (cmd_ff)
         CMD_INSERT: begin
            hit_in = (cnt_k < KW'(CAPACITY)) && (pos_k != '0)
                     && (pos_k <= cnt_k + KW'(1));
         end
         CMD_DEL_KEY, CMD_SEARCH: begin
            tgt_in = midx;
            hit_in = found;
         end
         CMD_DEL_AT, CMD_READ_AT: begin
            hit_in = (pos_k != '0) && (pos_k <= cnt_k);
         end
         CMD_CLEAR: begin
            hit_in = 1'b1;
         end
         default: begin
            hit_in = 1'b0;
         end
      endcase
   end

   // reads around the target cell
   assign tgt_p1  = tgt_ff + IW'(1);
   assign tgt_m1  = tgt_ff - IW'(1);
   assign nxt_ok  = (KW'(tgt_ff) + KW'(1)) < cnt_k;
   assign rd_item = cells_ff[tgt_ff];
   assign rd_prev = (tgt_ff != '0) ? cells_ff[tgt_m1] : '0;
   assign rd_next = nxt_ok ? cells_ff[tgt_p1] : '0;

   always_comb begin
      cells_in = cells_ff;
      cnt_in   = cnt_ff;
      if (ctl.apply && hit_ff) begin
         unique case (cmd_ff)
            CMD_INSERT: begin
               for (int i = 1; i < CAPACITY; i++) begin
                  if (i > int'(tgt_ff)) cells_in[i] = cells_ff[i-1];
               end
               for (int i = 0; i < CAPACITY; i++) begin
                  if (i == int'(tgt_ff)) cells_in[i] = val_ff;
               end
               cnt_in = cnt_ff + CW'(1);
            end
            CMD_DEL_KEY, CMD_DEL_AT: begin
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if (i >= int'(tgt_ff)) cells_in[i] = cells_ff[i+1];
               end
               cnt_in = cnt_ff - CW'(1);
            end
            CMD_CLEAR: begin
               cnt_in = '0;
            end
            default: begin
               cnt_in = cnt_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      cells_ff <= cells_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= cmd_type'(req_cmd);
         pos_ff <= req_position;
         val_ff <= req_value;
      end
      if (ctl.find) begin
         tgt_ff <= tgt_in;
         hit_ff <= hit_in;
      end
      if (ctl.apply) begin
         ok_ff      <= hit_ff;
         item_ff    <= '0;
         fpos_ff    <= '0;
         prev_ff    <= '0;
         next_ff    <= '0;
         last_ff    <= 1'b0;
         cnt_rsp_ff <= cnt_in;
         if (hit_ff) begin
            case (cmd_ff)
               CMD_DEL_KEY, CMD_DEL_AT, CMD_READ_AT: begin
                  item_ff <= rd_item;
               end
               CMD_SEARCH: begin
                  fpos_ff <= POS_W'(tgt_ff) + POS_W'(1);
                  prev_ff <= rd_prev;
                  next_ff <= rd_next;
                  last_ff <= !nxt_ok;
               end
               default: begin
                  item_ff <= '0;
               end
            endcase
         end
      end
   end

   assign rsp_ok             = ok_ff;
   assign rsp_item_value     = item_ff;
   assign rsp_found_position = fpos_ff;
   assign rsp_prev_value     = prev_ff;
   assign rsp_next_value     = next_ff;
   assign rsp_match_is_last  = last_ff;
   assign rsp_list_count     = COUNT_OUT_W'(cnt_rsp_ff);
   assign rsp_list_empty     = (cnt_rsp_ff == '0);

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      int'(cnt_ff) <= CAPACITY)
      else $error("count above capacity");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !ctl.apply |=> $stable(cnt_ff))
      else $error("count changed outside apply");

   a_full_insert: assert property (@(posedge clock) disable iff (reset)
      ctl.find && cmd_ff == CMD_INSERT && int'(cnt_ff) == CAPACITY |=> !hit_ff)
      else $error("insert accepted on full list");
`endif

endmodule

`default_nettype wire

// File: tb/sv/ordered_list_checker.sv
// ordered list checker: tracks the list, predicts each response word and compares it
module ordered_list_checker
   import olist_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   input  wire logic                     req_ready,
   input  wire logic [CMD_W-1:0]         req_cmd,
   input  wire logic [POS_W-1:0]         req_position,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic                     rsp_valid,
   input  wire logic                     rsp_ready,
   input  wire logic                     rsp_ok,
   input  wire logic signed [DATA_W-1:0] rsp_item_value,
   input  wire logic [POS_W-1:0]         rsp_found_position,
   input  wire logic signed [DATA_W-1:0] rsp_prev_value,
   input  wire logic signed [DATA_W-1:0] rsp_next_value,
   input  wire logic                     rsp_match_is_last,
   input  wire logic [COUNT_OUT_W-1:0]   rsp_list_count,
   input  wire logic                     rsp_list_empty,
   output int                            fail_count,
   output int                            pending
);

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] item_value;
      logic [POS_W-1:0]         found_position;
      logic signed [DATA_W-1:0] prev_value;
      logic signed [DATA_W-1:0] next_value;
      logic                     match_is_last;
      logic [COUNT_OUT_W-1:0]   list_count;
      logic                     list_empty;
   } list_reply_type;

   logic signed [DATA_W-1:0] list_cells [CAPACITY];
   int                       list_len = 0;
   list_reply_type           queued_replies [$];
   int                       errors = 0;

   function automatic int find_key(input logic signed [DATA_W-1:0] key);
      for (int i = 0; i < list_len; i++) begin
         if (list_cells[i] === key) return i;
      end
      return -1;
   endfunction

   function automatic void remove_at(input int idx);
      for (int i = idx; i + 1 < list_len; i++) begin
         list_cells[i] = list_cells[i + 1];
      end
      list_len--;
   endfunction

   function automatic list_reply_type apply_list_command(input logic [CMD_W-1:0] cmd,
                                                         input logic [POS_W-1:0] pos,
                                                         input logic signed [DATA_W-1:0] val);
      list_reply_type r;
      int             p;
      int             idx;
      r = '0;
      p = int'(pos);
      case (cmd)
         CMD_INSERT: begin
            if (list_len < CAPACITY && p >= 1 && p <= list_len + 1) begin
               for (int i = list_len; i > p - 1; i--) begin
                  list_cells[i] = list_cells[i - 1];
               end
               list_cells[p - 1] = val;
               list_len++;
               r.ok = 1'b1;
            end
         end
         CMD_DEL_KEY: begin
            idx = find_key(val);
            if (idx >= 0) begin
               r.item_value = list_cells[idx];
               remove_at(idx);
               r.ok = 1'b1;
            end
         end
         CMD_DEL_AT: begin
            if (p >= 1 && p <= list_len) begin
               r.item_value = list_cells[p - 1];
               remove_at(p - 1);
               r.ok = 1'b1;
            end
         end
         CMD_READ_AT: begin
            if (p >= 1 && p <= list_len) begin
               r.item_value = list_cells[p - 1];
               r.ok = 1'b1;
            end
         end
         CMD_SEARCH: begin
            idx = find_key(val);
            if (idx >= 0) begin
               r.ok = 1'b1;
               r.found_position = POS_W'(idx + 1);
               if (idx > 0) r.prev_value = list_cells[idx - 1];
               if (idx + 1 < list_len) r.next_value = list_cells[idx + 1];
               else r.match_is_last = 1'b1;
            end
         end
         CMD_CLEAR: begin
            list_len = 0;
            r.ok = 1'b1;
         end
         default: begin
         end
      endcase
      r.list_count = COUNT_OUT_W'(list_len);
      r.list_empty = (list_len == 0);
      return r;
   endfunction

   task automatic compare_field(input string name, input logic signed [63:0] want,
                                input logic signed [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      list_reply_type want;
      if (reset) begin
         list_len = 0;
         queued_replies.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (queued_replies.size() == 0) begin
               $error("response word with no request outstanding");
               errors++;
            end else begin
               want = queued_replies.pop_front();
               compare_field("ok", want.ok, rsp_ok);
               compare_field("item_value", $signed(want.item_value), rsp_item_value);
               compare_field("found_position", want.found_position, rsp_found_position);
               compare_field("prev_value", $signed(want.prev_value), rsp_prev_value);
               compare_field("next_value", $signed(want.next_value), rsp_next_value);
               compare_field("match_is_last", want.match_is_last, rsp_match_is_last);
               compare_field("list_count", want.list_count, rsp_list_count);
               compare_field("list_empty", want.list_empty, rsp_list_empty);
            end
         end
         if (req_valid && req_ready) begin
            queued_replies.push_back(apply_list_command(req_cmd, req_position, req_value));
         end
      end
      pending <= queued_replies.size();
      fail_count <= errors;
   end

endmodule

// File: tb/sv/ordered_list_engine_tb.sv
// testbench top for the ordered list engine: stimulus, handshake pacing and verdict
module ordered_list_engine_tb;
   import olist_pkg::*;

   localparam logic [CMD_W-1:0]         CMD_SPARE_A     = 3'd6;
   localparam logic [CMD_W-1:0]         CMD_SPARE_B     = 3'd7;
   localparam logic signed [DATA_W-1:0] VAL_MAX         = 32'sh7fffffff;
   localparam logic signed [DATA_W-1:0] VAL_MIN         = 32'sh80000000;
   localparam int                       IDLE_LIMIT      = 5000;
   localparam int                       HOLD_OFF_CYCLES = 300;
   localparam int                       PHASES          = 12;
   localparam int                       PHASE_WORDS     = 56;

   typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} mix_kind_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [CMD_W-1:0]         req_cmd = CMD_CLEAR;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic                     rsp_ok;
   logic signed [DATA_W-1:0] rsp_item_value;
   logic [POS_W-1:0]         rsp_found_position;
   logic signed [DATA_W-1:0] rsp_prev_value;
   logic signed [DATA_W-1:0] rsp_next_value;
   logic                     rsp_match_is_last;
   logic [COUNT_OUT_W-1:0]   rsp_list_count;
   logic                     rsp_list_empty;
   int                       fail_count;
   int                       pending;
   bit                       source_dense = 1'b0;
   bit                       sink_dense = 1'b0;
   bit                       sink_hold_request = 1'b0;
   logic signed [DATA_W-1:0] key_pool [8];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   ordered_list_engine dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ok(rsp_ok),
      .rsp_item_value(rsp_item_value),
      .rsp_found_position(rsp_found_position),
      .rsp_prev_value(rsp_prev_value),
      .rsp_next_value(rsp_next_value),
      .rsp_match_is_last(rsp_match_is_last),
      .rsp_list_count(rsp_list_count),
      .rsp_list_empty(rsp_list_empty)
   );

   ordered_list_checker list_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_position(req_position),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_ok(rsp_ok),
      .rsp_item_value(rsp_item_value),
      .rsp_found_position(rsp_found_position),
      .rsp_prev_value(rsp_prev_value),
      .rsp_next_value(rsp_next_value),
      .rsp_match_is_last(rsp_match_is_last),
      .rsp_list_count(rsp_list_count),
      .rsp_list_empty(rsp_list_empty),
      .fail_count(fail_count),
      .pending(pending)
   );

   function automatic int pick_gap(input bit dense);
      int r;
      r = $urandom_range(0, 99);
      if (dense || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [POS_W-1:0] pick_position();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return POS_W'($urandom_range(1, 3));
      if (r < 85) return POS_W'($urandom_range(0, 17));
      return POS_W'($urandom_range(0, 31));
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      if ($urandom_range(0, 99) < 70) return key_pool[$urandom_range(0, 7)];
      return $urandom;
   endfunction

   task automatic send_word(input logic [CMD_W-1:0] c, input logic [POS_W-1:0] p,
                            input logic signed [DATA_W-1:0] v);
      int gap;
      gap = pick_gap(source_dense);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= c;
      req_position <= p;
      req_value <= v;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_random_word(input mix_kind_type kind);
      int               ins_pct;
      int               r;
      logic [CMD_W-1:0] c;
      ins_pct = (kind == MIX_GROW) ? 60 : (kind == MIX_SHRINK) ? 15 : 35;
      r = $urandom_range(0, 99);
      if (r < ins_pct) begin
         c = CMD_INSERT;
      end else begin
         r = $urandom_range(0, 99);
         if (r < 25) c = CMD_DEL_KEY;
         else if (r < 45) c = CMD_DEL_AT;
         else if (r < 65) c = CMD_READ_AT;
         else if (r < 92) c = CMD_SEARCH;
         else if (r < 95) c = CMD_CLEAR;
         else if (r < 98) c = CMD_SPARE_A;
         else c = CMD_SPARE_B;
      end
      send_word(c, pick_position(), pick_value());
   endtask

   // response side pacing, including one long hold-off on request
   initial begin
      int hold;
      do @(posedge clock); while (reset);
      forever begin
         if (sink_hold_request) begin
            sink_hold_request = 1'b0;
            hold = HOLD_OFF_CYCLES;
         end else begin
            hold = pick_gap(sink_dense);
         end
         if (hold > 0) begin
            rsp_ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // no word moving for too long means a hang
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      mix_kind_type kind;
      key_pool[0] = VAL_MAX;
      key_pool[1] = VAL_MIN;
      key_pool[2] = '0;
      key_pool[3] = -1;
      key_pool[4] = 1;
      for (int i = 5; i < 8; i++) key_pool[i] = $urandom;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // empty list corners
      send_word(CMD_SEARCH, 5'd0, 32'sd5);
      send_word(CMD_DEL_KEY, 5'd3, 32'sd5);
      send_word(CMD_READ_AT, 5'd1, $urandom);
      send_word(CMD_DEL_AT, 5'd0, $urandom);
      send_word(CMD_INSERT, 5'd0, 32'sd7);
      send_word(CMD_INSERT, 5'd2, 32'sd7);
      // build -1, max, min, 0
      send_word(CMD_INSERT, 5'd1, VAL_MAX);
      send_word(CMD_INSERT, 5'd2, VAL_MIN);
      send_word(CMD_INSERT, 5'd1, -32'sd1);
      send_word(CMD_INSERT, 5'd4, 32'sd0);
      send_word(CMD_INSERT, 5'd6, 32'sd9);
      send_word(CMD_READ_AT, 5'd0, $urandom);
      send_word(CMD_READ_AT, 5'd4, $urandom);
      send_word(CMD_READ_AT, 5'd5, $urandom);
      // search middle, first, last and absent
      send_word(CMD_SEARCH, 5'd31, VAL_MAX);
      send_word(CMD_SEARCH, 5'd0, -32'sd1);
      send_word(CMD_SEARCH, 5'd16, 32'sd0);
      send_word(CMD_SEARCH, 5'd2, 32'sd12345);
      send_word(CMD_DEL_KEY, 5'd1, 32'sd999);
      send_word(CMD_DEL_KEY, 5'd0, VAL_MIN);
      send_word(CMD_DEL_AT, 5'd3, $urandom);
      send_word(CMD_DEL_AT, 5'd3, $urandom);
      send_word(CMD_SPARE_A, 5'd31, $urandom);
      send_word(CMD_SPARE_B, 5'd1, VAL_MAX);
      send_word(CMD_CLEAR, 5'd17, $urandom);

      for (int ph = 0; ph < PHASES; ph++) begin
         kind = mix_kind_type'(ph % 3);
         source_dense = (ph % 5 == 4);
         sink_dense = (ph % 5 == 4) || (ph == 7);
         if (ph == 3) sink_hold_request = 1'b1;
         for (int i = 0; i < 8; i++) begin
            if ($urandom_range(0, 1) == 1) key_pool[i] = $urandom;
         end
         repeat (PHASE_WORDS) send_random_word(kind);
      end
      req_valid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/olist_pkg.sv
sv/olist_ctrl.sv
sv/olist_dp.sv
sv/ordered_list_engine.sv
tb/sv/ordered_list_checker.sv
tb/sv/ordered_list_engine_tb.sv
